FILE: rtl/cv5_pkg.sv
// shared types and constants for the 5x5 convolution block
`timescale 1ns / 1ps
package cv5_pkg;
	localparam int MASK_SIZE = 5;
	localparam int RADIUS = MASK_SIZE / 2;
	localparam int LINES = MASK_SIZE - 1;
	localparam int TAPS = MASK_SIZE * MASK_SIZE;
	localparam int TREE_LV = $clog2(TAPS);
	localparam int TREE_N = 1 << TREE_LV;
	localparam int LAT = TREE_LV + 3;
	localparam int NCH = 3;
	localparam int PIX_W = 16;
	localparam int COEF_W = 18;
	localparam int FRAC = 12;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int ROW_W = 13;
	localparam int OROW_W = 12;
	localparam int OCOL_W = 10;
	localparam int WCFG_W = 11;
	localparam int HCFG_W = 13;
	localparam int CCFG_W = 2;
	localparam int IDX_W = 5;
	localparam int STEP_W = $clog2(RADIUS + 1);

	typedef enum logic [1:0] {
		FN_COEF  = 2'd0,
		FN_PIXEL = 2'd1,
		FN_FLUSH = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CFG_WIDTH    = 2'd0,
		CFG_HEIGHT   = 2'd1,
		CFG_CHANNELS = 2'd2,
		CFG_NONE     = 2'd3
	} cfg_idx_t;

	typedef logic [NCH-1:0][PIX_W-1:0] px3_t;

	typedef struct packed {
		logic               vld;
		logic [OROW_W-1:0]  row;
		logic [OCOL_W-1:0]  col;
		logic               lrun;
		logic               lframe;
	} tag_t;
endpackage

FILE: rtl/cv5_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module cv5_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;
endmodule

FILE: rtl/cv5_lane.sv
// one channel lane: tap multipliers, registered adder tree, shift and clamp
`timescale 1ns / 1ps
module cv5_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic [cv5_pkg::PIX_W-1:0]         pix  [cv5_pkg::TAPS],
	input  logic signed [cv5_pkg::COEF_W-1:0] coef [cv5_pkg::TAPS],
	output logic [cv5_pkg::PIX_W-1:0]         res
);
	import cv5_pkg::*;

	localparam int PW = PIX_W + 1 + COEF_W;
	localparam int SW = PW + TREE_LV;
	localparam logic signed [SW-1:0] ONE = SW'(1) <<< (PIX_W - 1);

	logic signed [SW-1:0] sum_s [TREE_LV+1][TREE_N];
	logic [PIX_W-1:0] res_q;
	logic signed [SW-1:0] acc;
	logic signed [SW-1:0] shr;

	for (genvar i = 0; i < TREE_N; i++) begin : g_mul
		if (i < TAPS) begin : g_tap
			always_ff @(posedge clk) begin
				if (en) begin
					sum_s[0][i] <= SW'($signed({1'b0, pix[i]}) * coef[i]);
				end
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				if (en) begin
					sum_s[0][i] <= '0;
				end
			end
		end
	end

	for (genvar l = 0; l < TREE_LV; l++) begin : g_lvl
		for (genvar i = 0; i < TREE_N; i++) begin : g_add
			if (i < (TREE_N >> (l + 1))) begin : g_live
				always_ff @(posedge clk) begin
					if (en) begin
						sum_s[l+1][i] <= sum_s[l][2*i] + sum_s[l][2*i+1];
					end
				end
			end else begin : g_dead
				always_ff @(posedge clk) begin
					if (en) begin
						sum_s[l+1][i] <= '0;
					end
				end
			end
		end
	end

	assign acc = sum_s[TREE_LV][0];
	assign shr = acc >>> FRAC;

	always_ff @(posedge clk) begin
		if (en) begin
			if (acc <= 0) begin
				res_q <= '0;
			end else if (shr > ONE) begin
				res_q <= PIX_W'(ONE);
			end else begin
				res_q <= shr[PIX_W-1:0];
			end
		end
	end

	assign res = res_q;
endmodule

FILE: rtl/conv2d_5x5_clamped.sv
// top level: line buffer, sliding window, channel lanes and output merge
// throughput: one item per cycle while the output is not stalled; the last column
// of a row holds the input while the window shifts in the zero columns after the row
// reset clears counters, coefficients, window control and config to defaults;
// the line memory is not cleared, rows not yet written are masked by row count
`timescale 1ns / 1ps
module conv2d_5x5_clamped #(
	parameter int MAX_WIDTH = cv5_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [1:0]                         func,
	input  logic [cv5_pkg::IDX_W-1:0]          coef_index,
	input  logic signed [cv5_pkg::COEF_W-1:0]  coef_value,
	input  logic [cv5_pkg::PIX_W-1:0]          pixel_ch0,
	input  logic [cv5_pkg::PIX_W-1:0]          pixel_ch1,
	input  logic [cv5_pkg::PIX_W-1:0]          pixel_ch2,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [cv5_pkg::PIX_W-1:0]          out_ch0,
	output logic [cv5_pkg::PIX_W-1:0]          out_ch1,
	output logic [cv5_pkg::PIX_W-1:0]          out_ch2,
	output logic [cv5_pkg::OROW_W-1:0]         out_row,
	output logic [cv5_pkg::OCOL_W-1:0]         out_col,
	output logic                               last_of_run,
	output logic                               last_of_frame,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [cv5_pkg::HCFG_W-1:0]         cfg_data
);
	import cv5_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = LINES * NCH * PIX_W;

	logic [WCFG_W-1:0] width_q;
	logic [HCFG_W-1:0] height_q;
	logic [CCFG_W-1:0] chans_q;
	logic signed [COEF_W-1:0] coef_q [TAPS];
	logic [CW-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic s1_v_q;
	func_t s1_func_q;
	logic [IDX_W-1:0] s1_idx_q;
	logic signed [COEF_W-1:0] s1_coef_q;
	px3_t s1_cur_q;
	logic [CW-1:0] s1_col_q;
	logic [ROW_W-1:0] s1_row_q;
	logic s1_last_q;
	logic s1_fend_q;
	logic [STEP_W-1:0] step_q;

	logic fwd_q;
	logic [LW-1:0] fwd_d_q;
	px3_t win_q [MASK_SIZE][MASK_SIZE];
	tag_t tag_q [LAT];

	logic [CW:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	logic last_col, frame_end;
	logic acc, is_px, adv, proc, done, s1_px, emit, lrun;
	px3_t cur_in;
	logic we, re;
	logic [LW-1:0] rdata, wdata, line_flat;
	px3_t [LINES-1:0] line_px, new_px;
	px3_t colv [MASK_SIZE];
	logic clear;
	logic [CW+1:0] colk;
	logic [PIX_W-1:0] lane_pix [NCH][TAPS];
	logic [PIX_W-1:0] lane_res [NCH];
	logic [PIX_W-1:0] och [NCH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WCFG_W'(1024);
			height_q <= HCFG_W'(1024);
			chans_q <= CCFG_W'(3);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:    width_q <= cfg_data[WCFG_W-1:0];
				CFG_HEIGHT:   height_q <= cfg_data;
				CFG_CHANNELS: chans_q <= cfg_data[CCFG_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(width_q);
		end
		if (height_q == '0) begin
			h_eff = ROW_W'(1);
		end else if (32'(height_q) > HEIGHT_LIMIT) begin
			h_eff = ROW_W'(HEIGHT_LIMIT);
		end else begin
			h_eff = height_q;
		end
	end

	assign last_col = {1'b0, col_q} >= (w_eff - (CW+1)'(1));
	assign frame_end = last_col &&
		({1'b0, row_q} >= ({1'b0, h_eff} + (ROW_W+1)'(2 * RADIUS - 1)));

	assign adv = !(tag_q[LAT-1].vld && res_stall);
	assign s1_px = (s1_func_q == FN_PIXEL) || (s1_func_q == FN_FLUSH);
	assign proc = adv && s1_v_q;
	assign done = proc && (!s1_px || !s1_last_q || (step_q == STEP_W'(RADIUS)));
	assign item_stall = !(adv && (!s1_v_q || done));
	assign acc = item_valid && !item_stall;
	assign is_px = (func_t'(func) == FN_PIXEL) || (func_t'(func) == FN_FLUSH);

	always_comb begin
		cur_in = '0;
		if ((func_t'(func) == FN_PIXEL) && ({1'b0, row_q} < {1'b0, h_eff})) begin
			cur_in[0] = pixel_ch0;
			cur_in[1] = pixel_ch1;
			cur_in[2] = pixel_ch2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			step_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			s1_v_q <= 1'b1;
			step_q <= '0;
			if (is_px) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end else if (done) begin
			s1_v_q <= 1'b0;
			step_q <= '0;
		end else if (proc) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_func_q <= func_t'(func);
			s1_idx_q <= coef_index;
			s1_coef_q <= coef_value;
			s1_cur_q <= cur_in;
			s1_col_q <= col_q;
			s1_row_q <= row_q;
			s1_last_q <= last_col;
			s1_fend_q <= frame_end;
			fwd_q <= we && (s1_col_q == col_q);
			fwd_d_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (proc && (s1_func_q == FN_COEF) && (32'(s1_idx_q) < TAPS)) begin
			coef_q[s1_idx_q] <= s1_coef_q;
		end
	end

	assign re = acc && is_px;
	assign we = proc && s1_px && (step_q == '0);
	assign line_flat = fwd_q ? fwd_d_q : rdata;
	assign line_px = line_flat;

	always_comb begin
		for (int i = 0; i < LINES - 1; i++) begin
			new_px[i] = line_px[i+1];
		end
		new_px[LINES-1] = s1_cur_q;
	end
	assign wdata = new_px;

	cv5_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk(clk),
		.we(we),
		.waddr(s1_col_q),
		.wdata(wdata),
		.re(re),
		.raddr(col_q),
		.rdata(rdata)
	);

	always_comb begin
		for (int i = 0; i < LINES; i++) begin
			colv[i] = '0;
			if ((step_q == '0) && (32'(s1_row_q) >= (LINES - i))) begin
				colv[i] = line_px[i];
			end
		end
		colv[LINES] = (step_q == '0) ? s1_cur_q : '0;
	end

	assign clear = (step_q == '0) && (s1_col_q == '0);

	always_ff @(posedge clk) begin
		if (proc && s1_px) begin
			for (int i = 0; i < MASK_SIZE; i++) begin
				for (int j = 0; j < MASK_SIZE - 1; j++) begin
					win_q[i][j] <= clear ? '0 : win_q[i][j+1];
				end
				win_q[i][MASK_SIZE-1] <= colv[i];
			end
		end
	end

	assign colk = (CW+2)'(s1_col_q) + (CW+2)'(step_q);
	assign emit = s1_px && (32'(s1_row_q) >= RADIUS) && (32'(colk) >= RADIUS);
	assign lrun = !s1_last_q || (step_q == STEP_W'(RADIUS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < LAT; n++) begin
				tag_q[n] <= '0;
			end
		end else if (adv) begin
			tag_q[0].vld <= proc && emit;
			tag_q[0].row <= OROW_W'(s1_row_q - ROW_W'(RADIUS));
			tag_q[0].col <= OCOL_W'(colk - (CW+2)'(RADIUS));
			tag_q[0].lrun <= lrun;
			tag_q[0].lframe <= lrun && s1_fend_q;
			for (int n = 1; n < LAT; n++) begin
				tag_q[n] <= tag_q[n-1];
			end
		end
	end

	for (genvar k = 0; k < NCH; k++) begin : g_lane
		for (genvar t = 0; t < TAPS; t++) begin : g_tap
			assign lane_pix[k][t] = win_q[t / MASK_SIZE][t % MASK_SIZE][k];
		end
		cv5_lane u_lane (
			.clk(clk),
			.en(adv),
			.pix(lane_pix[k]),
			.coef(coef_q),
			.res(lane_res[k])
		);
		assign och[k] = (32'(chans_q) > k) ? lane_res[k] : '0;
	end

	assign res_valid = tag_q[LAT-1].vld;
	assign out_ch0 = och[0];
	assign out_ch1 = och[1];
	assign out_ch2 = och[2];
	assign out_row = tag_q[LAT-1].row;
	assign out_col = tag_q[LAT-1].col;
	assign last_of_run = tag_q[LAT-1].lrun;
	assign last_of_frame = tag_q[LAT-1].lframe;

`ifndef SYNTHESIS
	a_step_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && (step_q != '0)) |-> (s1_last_q && s1_px))
		else $error("extra shift step on a non row-end item");
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |-> item_stall)
		else $error("input taken while output blocked");
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last_of_frame) |-> last_of_run)
		else $error("frame end without run end");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q |-> (32'(step_q) <= RADIUS))
		else $error("shift step past radius");
`endif
endmodule

FILE: dv/conv2d_5x5_clamped_chk.sv
// result checker for the 5x5 convolution block: watches all three channels and predicts
`timescale 1ns / 1ps
module conv2d_5x5_clamped_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	input  logic                              item_stall,
	input  logic [1:0]                        func,
	input  logic [cv5_pkg::IDX_W-1:0]         coef_index,
	input  logic signed [cv5_pkg::COEF_W-1:0] coef_value,
	input  logic [cv5_pkg::PIX_W-1:0]         pixel_ch0,
	input  logic [cv5_pkg::PIX_W-1:0]         pixel_ch1,
	input  logic [cv5_pkg::PIX_W-1:0]         pixel_ch2,
	input  logic                              res_valid,
	input  logic                              res_stall,
	input  logic [cv5_pkg::PIX_W-1:0]         out_ch0,
	input  logic [cv5_pkg::PIX_W-1:0]         out_ch1,
	input  logic [cv5_pkg::PIX_W-1:0]         out_ch2,
	input  logic [cv5_pkg::OROW_W-1:0]        out_row,
	input  logic [cv5_pkg::OCOL_W-1:0]        out_col,
	input  logic                              last_of_run,
	input  logic                              last_of_frame,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [cv5_pkg::HCFG_W-1:0]        cfg_data,
	output int                                errors,
	output int                                pending
);
	import cv5_pkg::*;

	localparam int MW = MAX_WIDTH_DEF;

	typedef struct packed {
		logic [PIX_W-1:0]  c0, c1, c2;
		logic [OROW_W-1:0] row;
		logic [OCOL_W-1:0] col;
		logic              lrun, lframe;
	} pixel_result_t;

	pixel_result_t expected_pixels[$];
	logic signed [COEF_W-1:0] taps[TAPS];
	px3_t lines[LINES*MW];
	px3_t win[MASK_SIZE][MASK_SIZE];
	int unsigned row_cnt, col_cnt, width_reg, height_reg, chan_reg;

	assign pending = expected_pixels.size();

	function automatic void shift_window(input px3_t column[MASK_SIZE]);
		for (int i = 0; i < MASK_SIZE; i++) begin
			for (int j = 0; j < MASK_SIZE-1; j++) win[i][j] = win[i][j+1];
			win[i][MASK_SIZE-1] = column[i];
		end
	endfunction

	function automatic pixel_result_t convolve(input int unsigned r, input int unsigned c);
		pixel_result_t res;
		logic [PIX_W-1:0] v[NCH];
		longint acc;
		for (int k = 0; k < NCH; k++) begin
			acc = 0;
			v[k] = '0;
			if (k < chan_reg) begin
				for (int i = 0; i < MASK_SIZE; i++)
					for (int j = 0; j < MASK_SIZE; j++)
						acc += longint'(taps[i*MASK_SIZE+j]) * longint'(win[i][j][k]);
				if (acc > 0) begin
					acc = acc / 4096;
					if (acc > 32768) acc = 32768;
					v[k] = acc[PIX_W-1:0];
				end
			end
		end
		res.c0 = v[0]; res.c1 = v[1]; res.c2 = v[2];
		res.row = r[OROW_W-1:0];
		res.col = c[OCOL_W-1:0];
		res.lrun = 1'b0;
		res.lframe = 1'b0;
		return res;
	endfunction

	task automatic predict_item();
		int unsigned w, h, c, r, n;
		logic last_col, frame_end, emitting;
		px3_t cur;
		px3_t column[MASK_SIZE];
		px3_t zcol[MASK_SIZE];
		pixel_result_t batch[$];
		if (func == FN_COEF) begin
			if (coef_index < TAPS) taps[coef_index] = coef_value;
			return;
		end
		if (func == FN_NOP) return;
		w = width_reg == 0 ? 1 : (width_reg > MW ? MW : width_reg);
		h = height_reg == 0 ? 1 : (height_reg > HEIGHT_LIMIT ? HEIGHT_LIMIT : height_reg);
		c = col_cnt % MW;
		r = row_cnt;
		last_col = c >= w - 1;
		frame_end = last_col && r >= h + 2*RADIUS - 1;
		cur = '0;
		if (func == FN_PIXEL && r < h) begin
			cur[0] = pixel_ch0; cur[1] = pixel_ch1; cur[2] = pixel_ch2;
		end
		if (c == 0)
			for (int i = 0; i < MASK_SIZE; i++)
				for (int j = 0; j < MASK_SIZE; j++) win[i][j] = '0;
		for (int i = 0; i < LINES; i++) begin
			column[i] = '0;
			if (r >= LINES - i) column[i] = lines[((r - (LINES - i)) % LINES)*MW + c];
		end
		column[LINES] = cur;
		shift_window(column);
		lines[(r % LINES)*MW + c] = cur;
		emitting = r >= RADIUS;
		if (emitting && c >= RADIUS) batch.push_back(convolve(r - RADIUS, c - RADIUS));
		if (last_col) begin
			for (int i = 0; i < MASK_SIZE; i++) zcol[i] = '0;
			for (int k = 1; k <= RADIUS; k++) begin
				shift_window(zcol);
				if (emitting && c + k >= RADIUS)
					batch.push_back(convolve(r - RADIUS, c + k - RADIUS));
			end
		end
		n = batch.size();
		if (n > 0) begin
			batch[n-1].lrun = 1'b1;
			batch[n-1].lframe = frame_end;
		end
		foreach (batch[i]) expected_pixels.push_back(batch[i]);
		if (last_col) begin
			col_cnt = 0;
			row_cnt = frame_end ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	task automatic compare_result();
		pixel_result_t exp_r, act;
		act = '{out_ch0, out_ch1, out_ch2, out_row, out_col, last_of_run, last_of_frame};
		if (expected_pixels.size() == 0) begin
			$display("%0t: unexpected result transaction, actual %h", $time, act);
			errors++;
			return;
		end
		exp_r = expected_pixels.pop_front();
		if (exp_r != act) begin
			$display("%0t: mismatch: expected ch %h %h %h row %0d col %0d run %b frame %b",
				$time, exp_r.c0, exp_r.c1, exp_r.c2, exp_r.row, exp_r.col, exp_r.lrun,
				exp_r.lframe);
			$display("%0t:           actual ch %h %h %h row %0d col %0d run %b frame %b",
				$time, act.c0, act.c1, act.c2, act.row, act.col, act.lrun, act.lframe);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			expected_pixels.delete();
			foreach (taps[i]) taps[i] = '0;
			for (int i = 0; i < MASK_SIZE; i++)
				for (int j = 0; j < MASK_SIZE; j++) win[i][j] = '0;
			row_cnt = 0;
			col_cnt = 0;
			width_reg = 1024;
			height_reg = 1024;
			chan_reg = 3;
		end else begin
			if (res_valid && !res_stall) compare_result();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WIDTH: begin
						width_reg = cfg_data[WCFG_W-1:0];
					end
					CFG_HEIGHT: begin
						height_reg = cfg_data;
					end
					CFG_CHANNELS: begin
						chan_reg = cfg_data[CCFG_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (item_valid && !item_stall) predict_item();
		end
	end
endmodule

FILE: dv/conv2d_5x5_clamped_tb.sv
// testbench top for the 5x5 convolution block: stimulus, configuration and verdict
`timescale 1ns / 1ps
module conv2d_5x5_clamped_tb;
	import cv5_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0, item_stall;
	logic [1:0] func = FN_NOP;
	logic [IDX_W-1:0] coef_index = '0;
	logic signed [COEF_W-1:0] coef_value = '0;
	logic [PIX_W-1:0] pixel_ch0 = '0, pixel_ch1 = '0, pixel_ch2 = '0;
	logic res_valid, res_stall = 1'b0;
	logic [PIX_W-1:0] out_ch0, out_ch1, out_ch2;
	logic [OROW_W-1:0] out_row;
	logic [OCOL_W-1:0] out_col;
	logic last_of_run, last_of_frame;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [1:0] cfg_index = CFG_WIDTH;
	logic [HCFG_W-1:0] cfg_data = '0;
	int errors, pending;
	int items_sent, frames_run;
	bit idle_enable = 1'b1;

	always #5 clk = ~clk;

	conv2d_5x5_clamped uut (.*);
	conv2d_5x5_clamped_chk chk (.*);

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver stalls in random bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_enable && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic [1:0] f, input logic [IDX_W-1:0] idx,
		input logic signed [COEF_W-1:0] cv, input logic [PIX_W-1:0] p0,
		input logic [PIX_W-1:0] p1, input logic [PIX_W-1:0] p2);
		if (idle_enable && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		item_valid <= 1'b1;
		func <= f; coef_index <= idx; coef_value <= cv;
		pixel_ch0 <= p0; pixel_ch1 <= p1; pixel_ch2 <= p2;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic go_idle();
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LAT + 6) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [HCFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'hFFFF;
			default: return PIX_W'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic load_mask(input int kind);
		logic signed [COEF_W-1:0] v;
		for (int i = 0; i < TAPS; i++) begin
			case (kind)
				0: v = (i == 12) ? 18'sd4096 : 18'sd0;
				1: v = $urandom_range(0, 1) ? 18'sh1FFFF : -18'sh20000;
				default: v = $urandom_range(0, 3) == 0 ? COEF_W'($urandom) :
					COEF_W'($signed($urandom_range(0, 2048)) - 1024);
			endcase
			send_item(FN_COEF, IDX_W'(i), v, '0, '0, '0);
		end
	endtask

	// one frame plus flush; mangled frames mix in mismatched codes
	task automatic run_frame(input int w, input int h, input bit mangle);
		logic [1:0] f;
		for (int r = 0; r < h + 2*RADIUS; r++)
			for (int c = 0; c < w; c++) begin
				f = r < h ? FN_PIXEL : FN_FLUSH;
				if (mangle && $urandom_range(0, 7) == 0) f = 2'($urandom_range(1, 2));
				if (mangle && $urandom_range(0, 15) == 0)
					send_item(FN_NOP, IDX_W'($urandom), COEF_W'($urandom),
						PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
				send_item(f, '0, '0, rand_pixel(), rand_pixel(), rand_pixel());
			end
		frames_run++;
	endtask

	initial begin
		items_sent = 0;
		frames_run = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: identity mask, tiny frame, extremes, ignored codes
		write_reg(CFG_WIDTH, 13'd3);
		write_reg(CFG_HEIGHT, 13'd2);
		write_reg(CFG_CHANNELS, 13'd3);
		send_item(FN_COEF, 5'd31, 18'sh1FFFF, '0, '0, '0);
		send_item(FN_NOP, '1, '1, '1, '1, '1);
		load_mask(0);
		run_frame(3, 2, 1'b0);
		go_idle();
		write_reg(CFG_WIDTH, 13'd0);
		write_reg(CFG_HEIGHT, 13'd0);
		write_reg(CFG_CHANNELS, 13'd0);
		run_frame(1, 1, 1'b0);
		go_idle();
		// random phases
		while (items_sent < 280) begin
			write_reg(CFG_WIDTH, $urandom_range(0, 3) == 0 ? 13'd1 :
				HCFG_W'($urandom_range(1, 9)));
			write_reg(CFG_HEIGHT, HCFG_W'($urandom_range(1, 6)));
			write_reg(CFG_CHANNELS, HCFG_W'($urandom_range(0, 3)));
			load_mask($urandom_range(0, 3) == 0 ? 1 : 2);
			run_frame(width_now(), height_now(), $urandom_range(0, 2) == 0);
			go_idle();
		end
		// without idling: wider frame, oversized config, then final stretch
		write_reg(CFG_WIDTH, 13'd12);
		write_reg(CFG_HEIGHT, 13'd1);
		write_reg(CFG_CHANNELS, 13'd3);
		idle_enable = 1'b0;
		run_frame(12, 1, 1'b0);
		go_idle();
		write_reg(CFG_WIDTH, 13'h7FF);
		write_reg(CFG_HEIGHT, 13'h1FFF);
		write_reg(CFG_WIDTH, 13'd4);
		write_reg(CFG_HEIGHT, 13'd3);
		run_frame(4, 3, 1'b0);
		go_idle();
		$display("run covered %0d input transactions over %0d frames", items_sent, frames_run);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int width_now();
		return chk.width_reg == 0 ? 1 : int'(chk.width_reg);
	endfunction

	function automatic int height_now();
		return chk.height_reg == 0 ? 1 : int'(chk.height_reg);
	endfunction
endmodule

FILE: files.f
rtl/cv5_pkg.sv
rtl/cv5_ram.sv
rtl/cv5_lane.sv
rtl/conv2d_5x5_clamped.sv
dv/conv2d_5x5_clamped_chk.sv
dv/conv2d_5x5_clamped_tb.sv
